// ===== hdl/assert_macros.svh =====
// Assertion macros used by the list engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cond holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that cons holds in any cycle where ante holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, cond)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/alist_pkg.sv =====
// Types and codes shared by the list engine modules.
package alist_pkg;

    localparam int ActionW = 3;
    localparam int PosW    = 7;
    localparam int ValueW  = 32;
    localparam int StatusW = 2;
    localparam int CountW  = 8;

    localparam logic [ActionW-1:0] ACT_FIND        = 3'd0;
    localparam logic [ActionW-1:0] ACT_APPEND      = 3'd1;
    localparam logic [ActionW-1:0] ACT_REMOVE_LAST = 3'd2;
    localparam logic [ActionW-1:0] ACT_REMOVE_AT   = 3'd3;
    localparam logic [ActionW-1:0] ACT_INSERT_AT   = 3'd4;

    localparam logic [StatusW-1:0] STAT_OK   = 2'd0;
    localparam logic [StatusW-1:0] STAT_NONE = 2'd1;
    localparam logic [StatusW-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [ActionW-1:0]       action;
        logic [PosW-1:0]          position;
        logic signed [ValueW-1:0] value;
    } alist_req_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [PosW-1:0]    found_position;
        logic [CountW-1:0]  entry_count;
    } alist_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_REMOVE,
        ST_INSERT,
        ST_PUT
    } alist_state_t;

endpackage

// ===== hdl/alist_mem.sv =====
// Entry storage: one write port, one read port with registered read data.
module alist_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic [alist_pkg::ValueW-1:0]          wdata,
    input  logic [AW-1:0]                         raddr,
    output logic [alist_pkg::ValueW-1:0]          rdata
);
    import alist_pkg::*;

    logic [ValueW-1:0] mem [DEPTH];
    logic [ValueW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/alist_ctrl.sv =====
// Sequencer: walks the entry memory one word per cycle for find and shifts.
`include "assert_macros.svh"
module alist_ctrl #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CW    = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  alist_pkg::alist_req_t        request,
    output logic                         busy,
    input  logic [alist_pkg::ValueW-1:0] rdata,
    output logic                         we,
    output logic [AW-1:0]                waddr,
    output logic [alist_pkg::ValueW-1:0] wdata,
    output logic [AW-1:0]                raddr,
    output logic                         done,
    output alist_pkg::alist_result_t     result
);
    import alist_pkg::*;

    localparam int XW = (CW > PosW) ? CW : PosW;

    alist_state_t      state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [ValueW-1:0] key_reg, key_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              run_reg, run_next;

    logic          accept;
    logic          full;
    logic          pos_below;
    logic          hit;
    logic          idx_below;
    logic [CW-1:0] req_pos;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = (count_reg == CW'(DEPTH));
    assign pos_below = (XW'(request.position) < XW'(count_reg));
    assign req_pos   = CW'(request.position);
    assign hit       = pend_reg && (rdata == key_reg);
    assign idx_below = (idx_reg < count_reg);
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.action)
                        ACT_FIND:
                        begin
                            state_next = ST_FIND;
                        end
                        ACT_REMOVE_AT:
                        begin
                            if ((count_reg != '0) && pos_below)
                            begin
                                state_next = ST_REMOVE;
                            end
                        end
                        ACT_INSERT_AT:
                        begin
                            if (!full && pos_below)
                            begin
                                state_next = ST_INSERT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                if (hit || !idx_below)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REMOVE:
            begin
                if (!idx_below)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                if (!run_reg)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next            = count_reg;
        idx_next              = idx_reg;
        pos_next              = pos_reg;
        key_next              = key_reg;
        pend_next             = pend_reg;
        pend_addr_next        = pend_addr_reg;
        run_next              = run_reg;
        we                    = 1'b0;
        waddr                 = pend_addr_reg;
        wdata                 = rdata;
        raddr                 = idx_reg[AW-1:0];
        done                  = 1'b0;
        result.status         = STAT_NONE;
        result.found_position = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = request.value;
                    pos_next  = req_pos;
                    pend_next = 1'b0;
                    case (request.action)
                        ACT_FIND:
                        begin
                            idx_next = '0;
                        end
                        ACT_APPEND:
                        begin
                            done = 1'b1;
                            if (full)
                            begin
                                result.status = STAT_FULL;
                            end
                            else
                            begin
                                we            = 1'b1;
                                waddr         = count_reg[AW-1:0];
                                wdata         = request.value;
                                count_next    = count_reg + 1'b1;
                                result.status = STAT_OK;
                            end
                        end
                        ACT_REMOVE_LAST:
                        begin
                            done = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next    = count_reg - 1'b1;
                                result.status = STAT_OK;
                            end
                        end
                        ACT_REMOVE_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                done = 1'b1;
                            end
                            else if (pos_below)
                            begin
                                // shift down: read i+1, write i in the following cycle
                                idx_next = req_pos + 1'b1;
                            end
                            else
                            begin
                                done          = 1'b1;
                                result.status = STAT_OK;
                            end
                        end
                        ACT_INSERT_AT:
                        begin
                            if (full)
                            begin
                                done          = 1'b1;
                                result.status = STAT_FULL;
                            end
                            else if (pos_below)
                            begin
                                // shift up from the top: read i, write i+1
                                idx_next = count_reg - 1'b1;
                                run_next = 1'b1;
                            end
                            else
                            begin
                                done = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                if (hit)
                begin
                    done                  = 1'b1;
                    result.status         = STAT_OK;
                    result.found_position = PosW'(pend_addr_reg);
                    pend_next             = 1'b0;
                end
                else if (idx_below)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[AW-1:0];
                    idx_next       = idx_reg + 1'b1;
                end
                else
                begin
                    done      = 1'b1;
                    pend_next = 1'b0;
                end
            end
            ST_REMOVE:
            begin
                we = pend_reg;
                if (idx_below)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(idx_reg - 1'b1);
                    idx_next       = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next     = 1'b0;
                    count_next    = count_reg - 1'b1;
                    done          = 1'b1;
                    result.status = STAT_OK;
                end
            end
            ST_INSERT:
            begin
                we = pend_reg;
                if (run_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(idx_reg + 1'b1);
                    if (idx_reg == pos_reg)
                    begin
                        run_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_PUT:
            begin
                we            = 1'b1;
                waddr         = pos_reg[AW-1:0];
                wdata         = key_reg;
                count_next    = count_reg + 1'b1;
                done          = 1'b1;
                result.status = STAT_OK;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        result.entry_count = CountW'(count_next);
    end

    `ASSERT_HOLDS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH))
    `ASSERT_IMPL(a_put_room, clk, rst_n, state_reg == ST_PUT, count_reg < CW'(DEPTH))
    `ASSERT_IMPL(a_find_no_write, clk, rst_n, state_reg == ST_FIND, !we)
    `ASSERT_IMPL(a_full_status, clk, rst_n, done && (result.status == STAT_FULL),
                 full && (count_next == count_reg))

endmodule

// ===== hdl/array_list_engine.sv =====
// Top level of the packed list engine: sequencer, entry memory, result register.
//
// A request is taken when start is high and busy is low. Append, remove last,
// and every request that is rejected or does nothing finish in the cycle they
// are taken; find walks to a match or to the end of the list, remove and
// insert at position shift the tail of the list, and insert then writes the
// new value; the single read port of the entry memory moves one word per
// cycle. The result appears on result with done high for exactly one cycle,
// the cycle after the request finishes; the receiver cannot stall it, so a
// result that is not taken in that cycle is lost. Busy stays high while a
// walk over the memory is in progress. Entries hold no reset value; only
// entries below the count are ever used.
module array_list_engine #(
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  alist_pkg::alist_req_t    request,
    output logic                     busy,
    output logic                     done,
    output alist_pkg::alist_result_t result
);
    import alist_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ValueW-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ValueW-1:0] mem_rdata;

    logic          ctrl_done;
    alist_result_t ctrl_result;

    logic          done_reg;
    alist_result_t result_reg;

    // Sequencer: decodes the request and walks the memory for find and shifts.
    alist_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .rdata   (mem_rdata),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .done    (ctrl_done),
        .result  (ctrl_result)
    );

    // Entry storage.
    alist_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold each result on the output until the next one; the one-cycle done strobe marks the transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_done)
        begin
            result_reg <= ctrl_result;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
